// ===== hdl/sam_pkg.sv =====
// Shared types and constants for the stack arithmetic machine.
package sam_pkg;

  // Default number of stack entries
  localparam int unsigned SAM_STACK_DEPTH = 256;

  // Q16.16 value width and saturation limits
  localparam int unsigned QW = 32;
  localparam logic [QW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

  // Iterations of the shared unit
  localparam int unsigned MUL_STEPS = 32;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Instruction codes
  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_SUB     = 3'd1,
    CMD_MUL     = 3'd2,
    CMD_DIV     = 3'd3,
    CMD_NEG     = 3'd4,
    CMD_PUSH    = 3'd5,
    CMD_RET     = 3'd6,
    CMD_UNKNOWN = 3'd7
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RETURNED  = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_e;

  // Operations of the shared arithmetic unit
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_NEG
  } alu_op_e;

  // States of the shared arithmetic unit
  typedef enum logic [1:0] {
    A_IDLE,
    A_SIMPLE,
    A_ITER,
    A_FIX
  } alu_state_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EXEC,
    S_REFILL,
    S_FINISH
  } sam_state_e;

  // Request to the arithmetic unit
  typedef struct packed {
    logic           start;
    alu_op_e        op;
    logic [QW-1:0]  a;
    logic [QW-1:0]  b;
  } alu_req_t;

  // Response from the arithmetic unit
  typedef struct packed {
    logic           done;
    logic [QW-1:0]  result;
  } alu_rsp_t;

endpackage

// ===== hdl/sam_ram.sv =====
// Generic single-port RAM with registered read data.
module sam_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One access per cycle: write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ===== hdl/sam_alu.sv =====
// Shared Q16.16 arithmetic unit: one 34-bit adder, iterated for multiply and divide.
module sam_alu import sam_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  alu_state_e       state_q, state_d;
  alu_op_e          op_q, op_d;
  logic [QW-1:0]    a_q, a_d, b_q, b_d;
  logic [QW-1:0]    add_q, add_d;     // |a| for multiply, |b| for divide
  logic             neg_q, neg_d;
  logic [QW:0]      hi_q, hi_d;       // partial product or remainder
  logic [47:0]      lo_q, lo_d;       // multiplier bits or dividend/quotient
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [QW-1:0]    res_q, res_d;
  logic             done_q, done_d;

  logic [QW-1:0]    a_mag, b_mag;
  logic [33:0]      add_x, add_y, sum;
  logic             add_sub;
  logic [47:0]      mag;
  logic [QW:0]      shifted;
  logic             ovf;

  // Saturate a 34-bit signed sum to 32 bits
  function automatic logic [QW-1:0] sat34(input logic [33:0] s);
    logic [QW-1:0] r;
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
      r = s[QW-1:0];
    end else begin
      r = s[33] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  // Operand magnitudes; the most negative value maps to 2^31
  assign a_mag = req_i.a[QW-1] ? (~req_i.a + 32'd1) : req_i.a;
  assign b_mag = req_i.b[QW-1] ? (~req_i.b + 32'd1) : req_i.b;

  // Unsigned magnitude of the final result
  assign mag = (op_q == ALU_MUL) ? {hi_q[QW-1:0], lo_q[31:16]} : lo_q;

  // Divide step: next remainder bit shifted in
  assign shifted = {hi_q[QW-1:0], lo_q[47]};

  // Operand selection for the shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      A_SIMPLE: begin
        case (op_q)
          ALU_NEG: begin
            add_y   = {{2{a_q[QW-1]}}, a_q};
            add_sub = 1'b1;
          end
          ALU_SUB: begin
            add_x   = {{2{a_q[QW-1]}}, a_q};
            add_y   = {{2{b_q[QW-1]}}, b_q};
            add_sub = 1'b1;
          end
          default: begin
            add_x   = {{2{a_q[QW-1]}}, a_q};
            add_y   = {{2{b_q[QW-1]}}, b_q};
          end
        endcase
      end
      A_ITER: begin
        if (op_q == ALU_MUL) begin
          add_x = {1'b0, hi_q};
          add_y = {2'b00, add_q};
        end else begin
          add_x   = {1'b0, shifted};
          add_y   = {2'b00, add_q};
          add_sub = 1'b1;
        end
      end
      A_FIX: begin
        add_y   = {2'b00, mag[QW-1:0]};
        add_sub = neg_q;
      end
      default: ;
    endcase
  end

  assign sum = add_x + (add_sub ? ~add_y : add_y) + {33'd0, add_sub};

  // Magnitude out of the signed range
  assign ovf = neg_q ? ((mag[47:32] != '0) || (mag[31] && (mag[30:0] != '0)))
                     : (mag[47:31] != '0);

  // Sequencer of the unit
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    add_d   = add_q;
    neg_d   = neg_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          a_d   = req_i.a;
          b_d   = req_i.b;
          neg_d = req_i.a[QW-1] ^ req_i.b[QW-1];
          hi_d  = '0;
          if (req_i.op == ALU_MUL) begin
            add_d   = a_mag;
            lo_d    = {16'd0, b_mag};
            cnt_d   = CNT_W'(MUL_STEPS - 1);
            state_d = A_ITER;
          end else if (req_i.op == ALU_DIV) begin
            add_d   = b_mag;
            lo_d    = {a_mag, 16'd0};
            cnt_d   = CNT_W'(DIV_STEPS - 1);
            state_d = A_ITER;
          end else begin
            state_d = A_SIMPLE;
          end
        end
      end
      A_SIMPLE: begin
        res_d   = sat34(sum);
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_ITER: begin
        if (op_q == ALU_MUL) begin
          // add if multiplier bit set, then shift product right
          if (lo_q[0]) begin
            hi_d = sum[33:1];
            lo_d = {16'd0, sum[0], lo_q[31:1]};
          end else begin
            hi_d = {1'b0, hi_q[QW:1]};
            lo_d = {16'd0, hi_q[0], lo_q[31:1]};
          end
        end else begin
          // restoring divide step
          if (!sum[33]) begin
            hi_d = {1'b0, sum[QW-1:0]};
          end else begin
            hi_d = {1'b0, shifted[QW-1:0]};
          end
          lo_d = {lo_q[46:0], ~sum[33]};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = A_FIX;
        end
      end
      A_FIX: begin
        res_d   = ovf ? (neg_q ? Q_MIN : Q_MAX) : sum[QW-1:0];
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    add_q <= add_d;
    neg_q <= neg_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

// ===== hdl/stack_arithmetic_machine.sv =====
// Add, subtract and negate use the shared adder directly; multiply and divide iterate it
// 32 or 48 times. A divide by zero that leaves values behind refills the top from the stack.
// One instruction at a time: s_axis_tready is high only while the sequencer idles, and a
// finished result waits in the output register; the next result stalls until it is taken.
// Reset clears the sequencer, stack pointer and output valid; stack RAM is not cleared.
module stack_arithmetic_machine import sam_pkg::*; #(
  parameter int unsigned STACK_DEPTH = SAM_STACK_DEPTH,
  localparam int unsigned SpW  = $clog2(STACK_DEPTH + 1),
  localparam int unsigned OutW = ((QW + SpW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [31:0]     s_axis_tdata,   // [31:0] constant_value
  input  logic [2:0]      s_axis_tuser,   // [2:0] command
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,   // [31:0] top_value, [SpW+31:32] depth
  output logic [2:0]      m_axis_tuser    // [2:0] status
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  sam_state_e      state_q, state_d;
  cmd_e            cmd_q;
  logic [QW-1:0]   cv_q;
  status_e         status_q, status_d;
  logic [SpW-1:0]  sp_q, sp_d;
  logic [QW-1:0]   tos_q, tos_d;
  logic            out_valid_q, out_valid_d;
  logic [OutW-1:0] out_data_q, out_data_d;
  logic [2:0]      out_user_q, out_user_d;

  logic [SpW-1:0]  sp_m1, sp_m2, sp_m3;
  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [QW-1:0]   ram_wdata, ram_rdata;
  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;
  alu_op_e         bin_op;
  logic            accept;
  logic            is_binary;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign sp_m1  = sp_q - SpW'(1);
  assign sp_m2  = sp_q - SpW'(2);
  assign sp_m3  = sp_q - SpW'(3);

  // Binary command decode
  always_comb begin
    is_binary = 1'b1;
    bin_op    = ALU_ADD;
    case (cmd_q)
      CMD_ADD: bin_op = ALU_ADD;
      CMD_SUB: bin_op = ALU_SUB;
      CMD_MUL: bin_op = ALU_MUL;
      CMD_DIV: bin_op = ALU_DIV;
      default: is_binary = 1'b0;
    endcase
  end

  // Instruction sequencer
  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    sp_d        = sp_q;
    tos_d       = tos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    ram_we      = 1'b0;
    ram_addr    = sp_m1[AddrW-1:0];
    ram_wdata   = alu_rsp.result;
    alu_req     = '0;
    alu_req.op  = bin_op;
    alu_req.a   = ram_rdata;
    alu_req.b   = tos_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        if (is_binary) begin
          if (sp_q < SpW'(2)) begin
            status_d = ST_UNDERFLOW;
          end else if (cmd_q == CMD_DIV && tos_q == '0) begin
            // divide by zero drops both operands, fetch the new top
            status_d = ST_DIVZERO;
            sp_d     = sp_m2;
            ram_addr = sp_m3[AddrW-1:0];
            if (sp_q > SpW'(2)) begin
              state_d = S_REFILL;
            end
          end else begin
            ram_addr = sp_m2[AddrW-1:0];
            state_d  = S_READ;
          end
        end else begin
          case (cmd_q)
            CMD_NEG: begin
              if (sp_q == '0) begin
                status_d = ST_UNDERFLOW;
              end else begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_NEG;
                alu_req.a     = tos_q;
                state_d       = S_EXEC;
              end
            end
            CMD_PUSH: begin
              if (sp_q == SpW'(STACK_DEPTH)) begin
                status_d = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = sp_q[AddrW-1:0];
                ram_wdata = cv_q;
                tos_d     = cv_q;
                sp_d      = sp_q + SpW'(1);
              end
            end
            CMD_RET: status_d = ST_RETURNED;
            default: status_d = ST_UNKNOWN;
          endcase
        end
      end
      S_READ: begin
        // second operand now in the RAM output register
        alu_req.start = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          ram_we = 1'b1;
          tos_d  = alu_rsp.result;
          if (cmd_q == CMD_NEG) begin
            ram_addr = sp_m1[AddrW-1:0];
          end else begin
            ram_addr = sp_m2[AddrW-1:0];
            sp_d     = sp_m1;
          end
          state_d = S_FINISH;
        end
      end
      S_REFILL: begin
        tos_d   = ram_rdata;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_user_d  = status_q;
          out_data_d  = OutW'({sp_q, ((sp_q == '0) ? QW'(0) : tos_q)});
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(s_axis_tuser);
      cv_q  <= s_axis_tdata;
    end
    status_q   <= status_d;
    tos_q      <= tos_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  sam_ram #(
    .Width (QW),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sam_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  // Stack pointer never passes the stack size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // Arithmetic results only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == S_EXEC)
    else $error("arithmetic result outside execute state");

  // An accepted beat is decoded in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DECODE)
    else $error("accepted instruction not decoded");

  // Overflow is only reported on a full stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_OVERFLOW) |->
      m_axis_tdata[QW +: SpW] == SpW'(STACK_DEPTH))
    else $error("overflow reported with room on the stack");

  // An empty stack reports a zero top value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[QW +: SpW] == '0) |-> m_axis_tdata[QW-1:0] == '0)
    else $error("nonzero top value on empty stack");
`endif

endmodule
